/* rtl/bfp_pkg.sv */
// Package for the best-fit buffer pool evictor: shared types and codes.
// Used by the slot cell, the pool chain and the core.
`default_nettype none
package bfp_pkg;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RETURN  = 2'd1,
    OP_RECHECK = 2'd2,
    OP_SPARE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_FIT      = 3'd0,
    KIND_GROW     = 3'd1,
    KIND_NEW      = 3'd2,
    KIND_EVICTED  = 3'd3,
    KIND_ACCEPTED = 3'd4,
    KIND_DUP      = 3'd5,
    KIND_FULL     = 3'd6,
    KIND_RECHECK  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    CFG_LIMIT = 2'd0,
    CFG_AVAIL = 2'd1,
    CFG_RATIO = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_REMOVE,
    ST_EMIT,
    ST_CHECK
  } state_t;

  // One pooled buffer.
  typedef struct packed {
    logic [15:0] id;
    logic [30:0] verts;
    logic [30:0] idxs;
    logic [39:0] bytes;
  } entry_t;

  localparam int RatioOne = 65536;

  // Control from the core to the slot chain.
  typedef struct packed {
    logic scan_load;  // copy slots into the scan chain
    logic scan_shift; // advance scan chain by one
    logic append;     // write entry at the end
    logic remove;     // move last entry into the hole
  } chain_ctl_t;

endpackage
`default_nettype wire

/* rtl/bfp_if.sv */
// Valid/ready channel interface carrying a payload of type PAYLOAD_T.
// Depends on nothing; the payload type is set by the PAYLOAD_T parameter.
`default_nettype none
interface bfp_if #(parameter type PAYLOAD_T = logic) ();
  logic     valid;
  logic     ready;
  PAYLOAD_T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/bfp_cell.sv */
// One slot cell: a stored entry plus a scan register handing to its neighbour.
// Depends on bfp_pkg.
`default_nettype none
module bfp_cell (
  input  wire                  clk,
  input  wire bfp_pkg::chain_ctl_t ctl,
  input  wire                  wr_en,
  input  wire bfp_pkg::entry_t wr_data,
  input  wire bfp_pkg::entry_t scan_in,
  output bfp_pkg::entry_t      slot_q,
  output bfp_pkg::entry_t      scan_q
);
  bfp_pkg::entry_t slot_r, slot_nxt;
  bfp_pkg::entry_t scan_r, scan_nxt;

  // Load the slot on write, load or shift the scan copy.
  always_comb begin
    slot_nxt = wr_en ? wr_data : slot_r;
    scan_nxt = scan_r;
    if (ctl.scan_load) begin
      scan_nxt = slot_r;
    end else if (ctl.scan_shift) begin
      scan_nxt = scan_in;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    scan_r <= scan_nxt;
  end

  assign slot_q = slot_r;
  assign scan_q = scan_r;
endmodule
`default_nettype wire

/* rtl/bfp_chain.sv */
// Row of slot cells; cell 0 feeds the scan output, each cell shifts down.
// Depends on bfp_pkg and bfp_cell.
`default_nettype none
module bfp_chain #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire                  clk,
  input  wire bfp_pkg::chain_ctl_t ctl,
  input  wire [IW-1:0]         wr_idx,
  input  wire bfp_pkg::entry_t wr_data,
  input  wire [IW-1:0]         rd_idx,
  output bfp_pkg::entry_t      rd_data,
  output bfp_pkg::entry_t      scan_out
);
  bfp_pkg::entry_t slot_q [DEPTH];
  bfp_pkg::entry_t scan_q [DEPTH];

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    bfp_pkg::entry_t nb;
    logic            we;
    assign nb = (g == DEPTH - 1) ? scan_q[g] : scan_q[(g + 1) % DEPTH];
    assign we = (ctl.append || ctl.remove) && (wr_idx == IW'(g));
    bfp_cell u_cell (
      .clk(clk), .ctl(ctl), .wr_en(we), .wr_data(wr_data),
      .scan_in(nb), .slot_q(slot_q[g]), .scan_q(scan_q[g])
    );
  end

  assign scan_out = scan_q[0];
  assign rd_data  = slot_q[rd_idx];
endmodule
`default_nettype wire

/* rtl/best_fit_buffer_pool_evictor_core.sv */
// Best-fit buffer pool evictor, top level: control sequencer and result stage.
// Depends on bfp_pkg, bfp_if and bfp_chain.
//
// One item is worked at a time. The next is taken once the last result is delivered.
// The pooled slots are walked once through the shifting scan chain of cells, one
// entry per cycle, to find the best fit or the largest entry. Each eviction rescans
// once the previous result is taken, and output stalls delay every result.
`default_nettype none
module best_fit_buffer_pool_evictor_core #(
  parameter int POOL_DEPTH = 16
) (
  input wire clk,
  input wire rst_n,
  bfp_if.sink   in_ch,
  bfp_if.sink   cfg_ch,
  bfp_if.source out_ch
);
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] buffer_id;
    logic [30:0] want_vertices;
    logic [30:0] want_indices;
    logic [30:0] vertex_capacity;
    logic [30:0] index_capacity;
    logic [39:0] buffer_bytes;
  } in_t;

  in_t in_d;
  assign in_d = in_ch.data;

  // Configuration registers.
  logic [39:0] limit_r, avail_r;
  logic [16:0] ratio_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
      avail_r <= '0;
      ratio_r <= 17'd32768;
    end else if (cfg_ch.valid) begin
      unique case (bfp_pkg::cfg_idx_t'(cfg_ch.data.idx))
        bfp_pkg::CFG_LIMIT: limit_r <= cfg_ch.data.value[39:0];
        bfp_pkg::CFG_AVAIL: avail_r <= cfg_ch.data.value[39:0];
        bfp_pkg::CFG_RATIO: ratio_r <= cfg_ch.data.value[16:0];
        default: ;
      endcase
    end
  end

  // Byte limit, registered after the multiply.
  logic [16:0] ratio_c;
  logic [56:0] prod_r;
  logic        lim_en_r;
  logic [39:0] lim_r;
  assign ratio_c = (ratio_r > 17'(bfp_pkg::RatioOne)) ? 17'(bfp_pkg::RatioOne) : ratio_r;
  always_ff @(posedge clk) begin
    prod_r   <= avail_r * ratio_c;
    lim_en_r <= (limit_r != '0) || (avail_r != '0);
    lim_r    <= (limit_r != '0) ? limit_r : prod_r[55:16];
  end

  // Sequencer state.
  bfp_pkg::state_t st_r, st_nxt;
  in_t             item_r, item_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [43:0]     sum_r, sum_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [IW-1:0]   best_r, best_nxt;
  logic [IW-1:0]   big_r, big_nxt;
  logic            found_r, found_nxt;
  logic [39:0]     bb_r, bb_nxt;
  logic [39:0]     gb_r, gb_nxt;
  logic            evict_r, evict_nxt;
  logic            dup_r, dup_nxt;
  logic [30:0]     gv, gi;

  // Result register.
  logic            ov_r, ov_nxt;
  logic [2:0]      ok_r, ok_nxt;
  bfp_pkg::entry_t oe_r, oe_nxt;
  logic [30:0]     ogv_r, ogv_nxt, ogi_r, ogi_nxt;
  logic            ol_r, ol_nxt;

  bfp_pkg::chain_ctl_t ctl;
  logic [IW-1:0]       wr_idx, rd_idx;
  bfp_pkg::entry_t     wr_data, rd_data, scan_e, last_e;

  assign gv = (item_r.want_vertices < 31'd3) ? 31'd3 : item_r.want_vertices;
  assign gi = (item_r.want_indices < 31'd3) ? 31'd3 : item_r.want_indices;

  bfp_chain #(.DEPTH(POOL_DEPTH), .IW(IW)) u_chain (
    .clk(clk), .ctl(ctl), .wr_idx(wr_idx), .wr_data(wr_data),
    .rd_idx(rd_idx), .rd_data(rd_data), .scan_out(scan_e)
  );

  logic [IW-1:0] last_idx;
  assign last_idx = IW'(cnt_r - CW'(1));
  assign last_e   = rd_data;

  always_comb begin
    st_nxt = st_r; item_nxt = item_r; cnt_nxt = cnt_r; sum_nxt = sum_r;
    pos_nxt = pos_r; best_nxt = best_r; big_nxt = big_r; found_nxt = found_r;
    bb_nxt = bb_r; gb_nxt = gb_r; evict_nxt = evict_r; dup_nxt = dup_r;
    ov_nxt = ov_r; ok_nxt = ok_r; oe_nxt = oe_r; ogv_nxt = ogv_r;
    ogi_nxt = ogi_r; ol_nxt = ol_r;
    ctl = '0; wr_idx = IW'(cnt_r); wr_data = '0; rd_idx = last_idx;
    in_ch.ready = 1'b0;
    // Drop the result once taken.
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      bfp_pkg::ST_IDLE: begin
        in_ch.ready = !ov_r;
        if (in_ch.valid && !ov_r) begin
          item_nxt = in_d;
          ctl.scan_load = 1'b1;
          evict_nxt = (in_d.opcode != bfp_pkg::OP_REQUEST)
                   && (in_d.opcode != bfp_pkg::OP_RETURN);
          pos_nxt = '0; found_nxt = 1'b0; dup_nxt = 1'b0;
          st_nxt = bfp_pkg::ST_SCAN;
        end
      end
      bfp_pkg::ST_SCAN: begin
        // Walk one entry per cycle out of the scan chain.
        if (pos_r < cnt_r) begin
          ctl.scan_shift = 1'b1;
          if (scan_e.id == item_r.buffer_id) dup_nxt = 1'b1;
          if (pos_r == '0 || scan_e.bytes > gb_r) begin
            gb_nxt = scan_e.bytes; big_nxt = IW'(pos_r);
          end
          if (scan_e.verts >= gv && scan_e.idxs >= gi
              && (!found_r || scan_e.bytes < bb_r)) begin
            found_nxt = 1'b1; bb_nxt = scan_e.bytes; best_nxt = IW'(pos_r);
          end
          pos_nxt = pos_r + CW'(1);
        end else begin
          st_nxt = bfp_pkg::ST_PICK;
        end
      end
      bfp_pkg::ST_PICK: begin
        if (!ov_r || out_ch.ready) begin
          ogv_nxt = '0; ogi_nxt = '0; ol_nxt = 1'b1; ov_nxt = 1'b1;
          st_nxt = bfp_pkg::ST_IDLE;
          if (evict_r) begin
            priority if (lim_en_r && sum_r > 44'(lim_r) && cnt_r != '0) begin
              ov_nxt = ov_r && !out_ch.ready;
              rd_idx = big_r; best_nxt = big_r;
              st_nxt = bfp_pkg::ST_REMOVE;
            end else if (item_r.opcode == bfp_pkg::OP_RETURN) begin
              ov_nxt = ov_r && !out_ch.ready;
            end else begin
              ok_nxt = bfp_pkg::KIND_RECHECK; oe_nxt = '0;
            end
          end else if (item_r.opcode == bfp_pkg::OP_REQUEST) begin
            ogv_nxt = gv; ogi_nxt = gi;
            priority if (found_r) begin
              ok_nxt = bfp_pkg::KIND_FIT; best_nxt = best_r;
              st_nxt = bfp_pkg::ST_REMOVE; ov_nxt = ov_r && !out_ch.ready;
            end else if (cnt_r != '0) begin
              ok_nxt = bfp_pkg::KIND_GROW; best_nxt = big_r;
              st_nxt = bfp_pkg::ST_REMOVE; ov_nxt = ov_r && !out_ch.ready;
            end else begin
              ok_nxt = bfp_pkg::KIND_NEW; oe_nxt = '0;
            end
          end else begin
            oe_nxt = {item_r.buffer_id, item_r.vertex_capacity,
                      item_r.index_capacity, item_r.buffer_bytes};
            priority if (dup_r) begin
              ok_nxt = bfp_pkg::KIND_DUP;
            end else if (cnt_r >= CW'(POOL_DEPTH)) begin
              ok_nxt = bfp_pkg::KIND_FULL;
            end else begin
              ok_nxt = bfp_pkg::KIND_ACCEPTED;
              ctl.append = 1'b1; wr_data = oe_nxt;
              cnt_nxt = cnt_r + CW'(1);
              sum_nxt = sum_r + 44'(item_r.buffer_bytes);
              // Mark last unless the new total forces an eviction.
              ol_nxt = !(lim_en_r && sum_nxt > 44'(lim_r));
              evict_nxt = 1'b1;
              st_nxt = bfp_pkg::ST_CHECK;
            end
          end
        end
      end
      bfp_pkg::ST_REMOVE: begin
        // Capture the chosen entry; hole is filled next.
        rd_idx = best_r;
        oe_nxt = rd_data;
        sum_nxt = sum_r - 44'(rd_data.bytes);
        st_nxt = bfp_pkg::ST_EMIT;
      end
      bfp_pkg::ST_EMIT: begin
        // Move the last entry into the hole.
        rd_idx = last_idx;
        ctl.remove = 1'b1; wr_idx = best_r; wr_data = last_e;
        cnt_nxt = cnt_r - CW'(1);
        ov_nxt = 1'b1;
        if (evict_r) begin
          ok_nxt = bfp_pkg::KIND_EVICTED; ogv_nxt = '0; ogi_nxt = '0;
          // A return ends on its final eviction; a recheck still owes its done.
          ol_nxt = (item_r.opcode == bfp_pkg::OP_RETURN)
                && !(lim_en_r && sum_r > 44'(lim_r) && cnt_nxt != '0);
          st_nxt = bfp_pkg::ST_CHECK;
        end else begin
          ol_nxt = 1'b1; st_nxt = bfp_pkg::ST_IDLE;
        end
      end
      bfp_pkg::ST_CHECK: begin
        // Rescan for the next eviction once the result is gone.
        if (!ov_r) begin
          priority if (lim_en_r && sum_r > 44'(lim_r) && cnt_r != '0) begin
            ctl.scan_load = 1'b1; pos_nxt = '0; found_nxt = 1'b0;
            st_nxt = bfp_pkg::ST_SCAN;
          end else if (item_r.opcode == bfp_pkg::OP_RETURN) begin
            ol_nxt = 1'b1; ov_nxt = 1'b0; st_nxt = bfp_pkg::ST_IDLE;
          end else begin
            ok_nxt = bfp_pkg::KIND_RECHECK; oe_nxt = '0; ogv_nxt = '0;
            ogi_nxt = '0; ol_nxt = 1'b1; ov_nxt = 1'b1;
            st_nxt = bfp_pkg::ST_IDLE;
          end
        end
      end
      default: st_nxt = bfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bfp_pkg::ST_IDLE; cnt_r <= '0; sum_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; sum_r <= sum_nxt; ov_r <= ov_nxt;
    end
    item_r <= item_nxt; pos_r <= pos_nxt; best_r <= best_nxt; big_r <= big_nxt;
    found_r <= found_nxt; bb_r <= bb_nxt; gb_r <= gb_nxt; evict_r <= evict_nxt;
    dup_r <= dup_nxt; ok_r <= ok_nxt; oe_r <= oe_nxt; ogv_r <= ogv_nxt;
    ogi_r <= ogi_nxt; ol_r <= ol_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = {ok_r, oe_r.id, oe_r.verts, oe_r.idxs, oe_r.bytes,
                         ogv_r, ogi_r, sum_r, ol_r};

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(POOL_DEPTH)) else $error("pool count overflow");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (st_r == bfp_pkg::ST_IDLE)) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r) else $error("result dropped");
`endif
endmodule
`default_nettype wire
